>>> rtl/core/fcsg_pkg.sv
// Shared types and constants for the filled circle span generator.
// No dependencies; used by fcsg_span_unit and filled_circle_span_generator.
package fcsg_pkg;

    localparam int ORIGIN_W  = 12;
    localparam int RADIUS_W  = 4;
    localparam int COORD_W   = 13;
    localparam int STEP_W    = 5;   // loop x and y, neither exceeds the radius
    localparam int DEC_W     = 9;   // decision variable
    localparam int S_DATA_W  = 32;  // 28 bits of fields, padded
    localparam int M_DATA_W  = 40;  // 39 bits of fields, padded

    localparam logic [RADIUS_W-1:0] MAX_RADIUS = 4'd15;

    // Which of the four spans of one loop step is produced.
    typedef enum logic [1:0] {
        KIND_TOP     = 2'd0,  // row cy - x, half width y
        KIND_MIRROR  = 2'd1,  // row cy + x, half width y
        KIND_DIAG_UP = 2'd2,  // row cy - y, half width x
        KIND_DIAG_DN = 2'd3   // row cy + y, half width x
    } span_kind_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] row;
        logic signed [COORD_W-1:0] x_start;
        logic signed [COORD_W-1:0] x_end;
    } span_t;

    // Loop state handed to the span unit.
    typedef struct packed {
        span_kind_t                kind;
        logic        [STEP_W-1:0]  x;
        logic        [STEP_W-1:0]  y;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [DEC_W-1:0]   d;
    } loop_ctl_t;

endpackage

>>> rtl/core/filled_circle_span_generator.sv
// Top level: midpoint circle sequencer feeding a held-back span and output register.
// Depends on fcsg_pkg and fcsg_span_unit.
//
// Usage:
//   Input channel s_*: one circle command per transfer. s_tdata carries
//   origin_x [11:0], origin_y [23:12], radius [27:24]; s_tuser[0] is
//   centre_mode (1: origin is the centre, 0: origin is the top-left corner).
//   Output channel m_*: one filled span per transfer, m_tdata carries
//   span_y [12:0], span_x_start [25:13], span_x_end [38:26]; m_tlast marks
//   the final span of a circle. A radius of zero produces no transfer.
//   Timing: one span unit walks the midpoint loop, one span per cycle while
//   the receiver keeps up, then a loop-exit step and a flush step that moves
//   the held-back span out. Radius 15 gives 31 spans.
//   s_tready is high only while no command is in work, so commands are
//   taken one at a time; the last span may still wait in the output
//   register while the next command is taken.
//   A stalled receiver (m_tready low) freezes the sequencer; no span is lost.
//   Reset (aresetn low, synchronous) drops any command in work and any
//   pending span.
module filled_circle_span_generator
    import fcsg_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // origin_x, origin_y, radius, zero pad
    input  logic [0:0]          s_tuser,   // centre_mode
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // span_y, span_x_start, span_x_end, zero pad
    output logic                m_tlast
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TOP,
        ST_MIRROR,
        ST_DIAG_UP,
        ST_DIAG_DN,
        ST_FLUSH
    } state_t;

    state_t                    state_reg,   state_next;
    logic        [STEP_W-1:0]  x_reg,       x_next;
    logic        [STEP_W-1:0]  y_reg,       y_next;
    logic signed [DEC_W-1:0]   d_reg,       d_next;
    logic signed [COORD_W-1:0] cx_reg,      cx_next;
    logic signed [COORD_W-1:0] cy_reg,      cy_next;
    span_t                     pend_reg,    pend_next;
    logic                      pend_valid_reg, pend_valid_next;
    span_t                     out_reg,     out_next;
    logic                      out_valid_reg,  out_valid_next;
    logic                      out_last_reg,   out_last_next;

    loop_ctl_t                 ctl;
    span_t                     span;
    logic signed [DEC_W-1:0]   d_straight;
    logic signed [DEC_W-1:0]   d_diag;

    logic                      s_fire;
    logic                      out_free;
    logic                      adv;
    logic                      emit;
    logic signed [ORIGIN_W-1:0] in_ox;
    logic signed [ORIGIN_W-1:0] in_oy;
    logic        [RADIUS_W-1:0] in_r;
    logic        [RADIUS_W-1:0] r_sat;
    logic signed [COORD_W-1:0] corner_off;

    assign in_ox = $signed(s_tdata[ORIGIN_W-1:0]);
    assign in_oy = $signed(s_tdata[2*ORIGIN_W-1:ORIGIN_W]);
    assign in_r  = s_tdata[2*ORIGIN_W+RADIUS_W-1:2*ORIGIN_W];
    assign r_sat = (in_r > MAX_RADIUS) ? MAX_RADIUS : in_r;
    // top-left mode: centre is origin + r - 1
    assign corner_off = $signed({{(COORD_W-RADIUS_W){1'b0}}, r_sat}) - COORD_W'(1);

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    // a new span may be produced when the held-back slot is free or can move on
    assign adv      = !pend_valid_reg || out_free;

    always_comb begin
        unique case (state_reg)
            ST_MIRROR:  ctl.kind = KIND_MIRROR;
            ST_DIAG_UP: ctl.kind = KIND_DIAG_UP;
            ST_DIAG_DN: ctl.kind = KIND_DIAG_DN;
            default:    ctl.kind = KIND_TOP;
        endcase
        ctl.x  = x_reg;
        ctl.y  = y_reg;
        ctl.cx = cx_reg;
        ctl.cy = cy_reg;
        ctl.d  = d_reg;
    end

    fcsg_span_unit u_span (
        .ctl        (ctl),
        .span       (span),
        .d_straight (d_straight),
        .d_diag     (d_diag)
    );

    always_comb begin
        state_next      = state_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        d_next          = d_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_last_next   = out_last_reg;
        emit            = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    x_next = '0;
                    y_next = STEP_W'(r_sat);
                    d_next = DEC_W'(3) - $signed({{(DEC_W-RADIUS_W-1){1'b0}}, r_sat, 1'b0});
                    if (s_tuser[0]) begin
                        cx_next = COORD_W'(in_ox);
                        cy_next = COORD_W'(in_oy);
                    end else begin
                        cx_next = COORD_W'(in_ox) + corner_off;
                        cy_next = COORD_W'(in_oy) + corner_off;
                    end
                    state_next = (r_sat == '0) ? ST_IDLE : ST_TOP;
                end
            end
            ST_TOP: begin
                if (adv) begin
                    if (y_reg < x_reg) begin
                        state_next = ST_FLUSH;
                    end else begin
                        emit = 1'b1;
                        if (x_reg != '0) begin
                            state_next = ST_MIRROR;
                        end else if (d_reg < 0) begin
                            d_next = d_straight;
                            x_next = x_reg + STEP_W'(1);
                        end else if (x_reg != y_reg) begin
                            state_next = ST_DIAG_UP;
                        end else begin
                            d_next = d_diag;
                            x_next = x_reg + STEP_W'(1);
                            y_next = y_reg - STEP_W'(1);
                        end
                    end
                end
            end
            ST_MIRROR: begin
                if (adv) begin
                    emit = 1'b1;
                    if (d_reg < 0) begin
                        d_next     = d_straight;
                        x_next     = x_reg + STEP_W'(1);
                        state_next = ST_TOP;
                    end else if (x_reg != y_reg) begin
                        state_next = ST_DIAG_UP;
                    end else begin
                        d_next     = d_diag;
                        x_next     = x_reg + STEP_W'(1);
                        y_next     = y_reg - STEP_W'(1);
                        state_next = ST_TOP;
                    end
                end
            end
            ST_DIAG_UP: begin
                if (adv) begin
                    emit       = 1'b1;
                    state_next = ST_DIAG_DN;
                end
            end
            ST_DIAG_DN: begin
                if (adv) begin
                    emit       = 1'b1;
                    d_next     = d_diag;
                    x_next     = x_reg + STEP_W'(1);
                    y_next     = y_reg - STEP_W'(1);
                    state_next = ST_TOP;
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    out_next        = pend_reg;
                    out_valid_next  = 1'b1;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // in the loop a held-back span moves out only once its successor exists
        if (emit) begin
            if (pend_valid_reg) begin
                out_next       = pend_reg;
                out_valid_next = 1'b1;
                out_last_next  = 1'b0;
            end
            pend_next       = span;
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
        x_reg        <= x_next;
        y_reg        <= y_next;
        d_reg        <= d_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(M_DATA_W-3*COORD_W){1'b0}}, out_reg.x_end, out_reg.x_start,
                       out_reg.row};

`ifndef SYNTHESIS
    // flush always has a span to mark as last
    a_flush_has_span: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FLUSH) |-> pend_valid_reg)
        else $error("flush without pending span");

    // no span is held back between circles
    a_idle_no_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("pending span left while idle");

    // a span never runs backward
    a_span_order: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_reg.x_start <= out_reg.x_end))
        else $error("span start past end");

    // zero radius returns straight to idle
    a_zero_radius: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && (r_sat == '0)) |=> (state_reg == ST_IDLE))
        else $error("zero radius started a loop");
`endif

endmodule

>>> rtl/core/fcsg_span_unit.sv
// Shared span arithmetic: one span per call plus both decision updates.
// Depends on fcsg_pkg.
module fcsg_span_unit
    import fcsg_pkg::*;
(
    input  loop_ctl_t                ctl,
    output span_t                    span,
    output logic signed [DEC_W-1:0]  d_straight,  // d + 4x + 6
    output logic signed [DEC_W-1:0]  d_diag       // d + 4(x - y) + 10
);

    logic signed [COORD_W-1:0] row_off;
    logic signed [COORD_W-1:0] half;
    logic                      row_down;
    logic signed [DEC_W-1:0]   x_ext;
    logic signed [DEC_W-1:0]   y_ext;

    always_comb begin
        unique case (ctl.kind)
            KIND_TOP: begin
                row_off  = $signed({{(COORD_W-STEP_W){1'b0}}, ctl.x});
                half     = $signed({{(COORD_W-STEP_W){1'b0}}, ctl.y});
                row_down = 1'b0;
            end
            KIND_MIRROR: begin
                row_off  = $signed({{(COORD_W-STEP_W){1'b0}}, ctl.x});
                half     = $signed({{(COORD_W-STEP_W){1'b0}}, ctl.y});
                row_down = 1'b1;
            end
            KIND_DIAG_UP: begin
                row_off  = $signed({{(COORD_W-STEP_W){1'b0}}, ctl.y});
                half     = $signed({{(COORD_W-STEP_W){1'b0}}, ctl.x});
                row_down = 1'b0;
            end
            default: begin
                row_off  = $signed({{(COORD_W-STEP_W){1'b0}}, ctl.y});
                half     = $signed({{(COORD_W-STEP_W){1'b0}}, ctl.x});
                row_down = 1'b1;
            end
        endcase
    end

    assign span.row     = row_down ? ctl.cy + row_off : ctl.cy - row_off;
    assign span.x_start = ctl.cx - half;
    assign span.x_end   = ctl.cx + half;

    assign x_ext = $signed({{(DEC_W-STEP_W){1'b0}}, ctl.x});
    assign y_ext = $signed({{(DEC_W-STEP_W){1'b0}}, ctl.y});

    assign d_straight = ctl.d + (x_ext <<< 2) + DEC_W'(6);
    assign d_diag     = ctl.d + ((x_ext - y_ext) <<< 2) + DEC_W'(10);

endmodule

>>> tb/testbench.sv
// Testbench for filled_circle_span_generator: drives circle commands on s_*,
// checks every filled span on m_* against a local midpoint circle predictor.
// Depends on fcsg_pkg and the filled_circle_span_generator RTL.
`timescale 1ns / 1ps

module testbench;
    import fcsg_pkg::*;

    localparam int HOLD_LEN    = 300;
    localparam int DRAIN_WAIT  = 100;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [ORIGIN_W-1:0] ox;
        logic signed [ORIGIN_W-1:0] oy;
        logic        [RADIUS_W-1:0] radius;
        logic                       centred;
    } circle_cmd_t;

    typedef struct {
        span_t span;
        logic  last;
    } span_exp_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [0:0]          s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;

    circle_cmd_t pending_cmds[$];
    span_exp_t   span_expect_q[$];
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_req       = 0;
    int          hold_ack       = 0;
    int          hold_left      = 0;
    int          err_count      = 0;
    int          cycle_count    = 0;

    filled_circle_span_generator u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // origin_x, origin_y, radius, zero pad
        .s_tuser  (s_tuser),   // centre_mode
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // span_y, span_x_start, span_x_end, zero pad
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Midpoint circle walk; appends the spans of one command to the queue.
    function automatic void predict_circle_spans(circle_cmd_t cmd);
        int        cx, cy, x, y, d, r, first;
        span_exp_t e;
        r = cmd.radius;
        if (r > MAX_RADIUS) r = MAX_RADIUS;
        if (r == 0) return;
        cx = cmd.centred ? int'(cmd.ox) : int'(cmd.ox) + r - 1;
        cy = cmd.centred ? int'(cmd.oy) : int'(cmd.oy) + r - 1;
        x = 0;
        y = r;
        d = 3 - 2 * r;
        first = span_expect_q.size();
        e.last = 1'b0;
        while (y >= x) begin
            e.span.row     = COORD_W'(cy - x);
            e.span.x_start = COORD_W'(cx - y);
            e.span.x_end   = COORD_W'(cx + y);
            span_expect_q.push_back(e);
            if (x > 0) begin
                e.span.row = COORD_W'(cy + x);
                span_expect_q.push_back(e);
            end
            if (d < 0) begin
                d = d + 4 * x + 6;
                x = x + 1;
            end else begin
                if (x != y) begin
                    e.span.row     = COORD_W'(cy - y);
                    e.span.x_start = COORD_W'(cx - x);
                    e.span.x_end   = COORD_W'(cx + x);
                    span_expect_q.push_back(e);
                    e.span.row = COORD_W'(cy + y);
                    span_expect_q.push_back(e);
                end
                d = d + 4 * (x - y) + 10;
                x = x + 1;
                y = y - 1;
            end
        end
        if (span_expect_q.size() > first)
            span_expect_q[span_expect_q.size() - 1].last = 1'b1;
    endfunction

    // Driver: one command per transfer; predict on acceptance.
    always @(posedge aclk) begin : drive_cmds
        circle_cmd_t c, sent;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                sent.ox      = s_tdata[11:0];
                sent.oy      = s_tdata[23:12];
                sent.radius  = s_tdata[27:24];
                sent.centred = s_tuser[0];
                predict_circle_spans(sent);
            end
            if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                c = pending_cmds.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {4'b0, c.radius, c.oy, c.ox};
                s_tuser  <= c.centred;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, one long hold-off on request, span checking.
    always @(posedge aclk) begin : check_spans
        span_exp_t                 e;
        logic signed [COORD_W-1:0] got_row, got_xs, got_xe;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_row = m_tdata[12:0];
                got_xs  = m_tdata[25:13];
                got_xe  = m_tdata[38:26];
                if (span_expect_q.size() == 0) begin
                    $error("unexpected span transfer: span_y %0d x %0d..%0d last %0b",
                           got_row, got_xs, got_xe, m_tlast);
                    err_count++;
                end else begin
                    e = span_expect_q.pop_front();
                    if (got_row !== e.span.row) begin
                        $error("span_y: expected %0d, actual %0d", e.span.row, got_row);
                        err_count++;
                    end
                    if (got_xs !== e.span.x_start) begin
                        $error("span_x_start: expected %0d, actual %0d",
                               e.span.x_start, got_xs);
                        err_count++;
                    end
                    if (got_xe !== e.span.x_end) begin
                        $error("span_x_end: expected %0d, actual %0d", e.span.x_end, got_xe);
                        err_count++;
                    end
                    if (m_tlast !== e.last) begin
                        $error("last_span: expected %0b, actual %0b", e.last, m_tlast);
                        err_count++;
                    end
                end
            end
            if (hold_ack != hold_req) begin
                hold_ack  <= hold_req;
                hold_left <= HOLD_LEN;
                m_tready  <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic signed [ORIGIN_W-1:0] pick_origin();
        case ($urandom_range(7))
            0:       return -12'sd2048;
            1:       return 12'sd2047;
            2:       return 12'sd0;
            default: return ORIGIN_W'($urandom);
        endcase
    endfunction

    task automatic queue_cmd(int ox, int oy, int r, int centred);
        circle_cmd_t c;
        c.ox      = ORIGIN_W'(ox);
        c.oy      = ORIGIN_W'(oy);
        c.radius  = RADIUS_W'(r);
        c.centred = centred[0];
        pending_cmds.push_back(c);
    endtask

    // Sender holds back until all spans are in before the next phase.
    task automatic wait_all_spans();
        while (pending_cmds.size() != 0 || s_tvalid || span_expect_q.size() != 0)
            @(negedge aclk);
    endtask

    task automatic run_phase(int n, int s_idle, int r_stall, bit long_hold);
        send_idle_pct  = s_idle;
        recv_stall_pct = r_stall;
        if (long_hold) hold_req++;
        repeat (n)
            queue_cmd(pick_origin(), pick_origin(), $urandom_range(15), $urandom_range(1));
        wait_all_spans();
    endtask

    initial begin : stimulus
        int corner[4];
        corner = '{-2048, 2047, 0, -1};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: every radius with alternating modes, origins at the extremes, 0 and -1; then corners in both modes.
        for (int r = 0; r <= 15; r++)
            queue_cmd(corner[r % 4], corner[(r / 4) % 4], r, r % 2);
        for (int m = 0; m < 2; m++) begin
            queue_cmd(-2048, -2048, 15, m);
            queue_cmd(2047, 2047, 15, m);
            queue_cmd(-2048, 2047, 15, m);
            queue_cmd(2047, -2048, 1, m);
        end
        wait_all_spans();

        run_phase(26, 0, 0, 1'b0);
        run_phase(60, 75, 0, 1'b0);
        run_phase(60, 0, 75, 1'b0);
        run_phase(60, 12, 12, 1'b1);

        repeat (DRAIN_WAIT) @(negedge aclk);
        if (err_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
